[rtl/lpd_pkg.sv]
// lpd_pkg: shared types and constants of the long press detector
package lpd_pkg;

  localparam int COORD_BITS = 12;
  localparam int TIMER_BITS = 32;
  localparam int ID_BITS    = 4;
  localparam int DT_BITS    = 16;
  localparam int ALLOW_BITS = 12;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  // squared travel widths
  localparam int SQ_BITS   = 2 * COORD_BITS + 1;
  localparam int ASQ_BITS  = 2 * ALLOW_BITS;

  // event kinds
  localparam logic [2:0] REQ_BEGAN     = 3'd0;
  localparam logic [2:0] REQ_MOVED     = 3'd1;
  localparam logic [2:0] REQ_ENDED     = 3'd2;
  localparam logic [2:0] REQ_CANCELLED = 3'd3;
  localparam logic [2:0] REQ_TICK      = 3'd4;
  localparam logic [2:0] REQ_RESET     = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_PRESS_TIME = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALLOW_MOVEMENT = 2'd1;

  localparam logic [TIMER_BITS-1:0] MIN_PRESS_TIME_RST = TIMER_BITS'(500000);
  localparam logic [ALLOW_BITS-1:0] ALLOW_MOVEMENT_RST = ALLOW_BITS'(10);
  localparam logic [ASQ_BITS-1:0]   ALLOW_SQ_RST =
    ASQ_BITS'(ALLOW_MOVEMENT_RST) * ASQ_BITS'(ALLOW_MOVEMENT_RST);

  // reported phase codes
  localparam logic [1:0] PHASE_CODE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_CODE_PRESSING = 2'd1;
  localparam logic [1:0] PHASE_CODE_RECOG    = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_PRESSING = 3'b010,
    PH_RECOG    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic                  one_finger_valid;
    logic [ID_BITS-1:0]    touch_id;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [DT_BITS-1:0]    dt_us;
  } evt_t;

  typedef struct packed {
    logic [1:0] phase_after;
    logic       press_valid;
    logic       long_press_began;
    logic       long_press_failed;
  } res_t;

  typedef struct packed {
    phase_t                phase;
    logic [TIMER_BITS-1:0] hold_timer;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [ID_BITS-1:0]    start_id;
  } lpd_state_t;

endpackage

[rtl/lpd_step.sv]
// lpd_step: next-state and result logic for one touch event
module lpd_step
  import lpd_pkg::*;
(
  input  lpd_state_t            state,
  input  evt_t                  evt,
  input  logic [TIMER_BITS-1:0] min_press_time,
  input  logic [ASQ_BITS-1:0]   allow_sq,
  output lpd_state_t            state_next,
  output res_t                  res
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [SQ_BITS-1:0]    d2;
  logic [TIMER_BITS:0]   tsum;
  logic [TIMER_BITS-1:0] tsat;
  logic                  began;
  logic                  failed;

  always_comb begin
    dx = (evt.pos_x >= state.start_x) ? evt.pos_x - state.start_x
                                      : state.start_x - evt.pos_x;
    dy = (evt.pos_y >= state.start_y) ? evt.pos_y - state.start_y
                                      : state.start_y - evt.pos_y;
    d2 = SQ_BITS'(dx) * SQ_BITS'(dx) + SQ_BITS'(dy) * SQ_BITS'(dy);
    tsum = {1'b0, state.hold_timer} + (TIMER_BITS + 1)'(evt.dt_us);
    // saturate at all ones
    tsat = tsum[TIMER_BITS] ? '1 : tsum[TIMER_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    began      = 1'b0;
    failed     = 1'b0;
    case (evt.req_type)
      REQ_BEGAN: begin
        if (state.phase == PH_IDLE && evt.one_finger_valid) begin
          state_next.start_id   = evt.touch_id;
          state_next.start_x    = evt.pos_x;
          state_next.start_y    = evt.pos_y;
          state_next.hold_timer = '0;
          state_next.phase      = PH_PRESSING;
        end
      end
      REQ_MOVED: begin
        if (state.phase == PH_PRESSING && evt.touch_id == state.start_id &&
            d2 > SQ_BITS'(allow_sq)) begin
          state_next.phase = PH_IDLE;
        end
      end
      REQ_ENDED: begin
        failed           = (state.phase != PH_RECOG);
        state_next.phase = PH_IDLE;
      end
      REQ_CANCELLED: begin
        state_next.phase = PH_IDLE;
      end
      REQ_TICK: begin
        if (state.phase == PH_PRESSING) begin
          if (tsat > min_press_time) begin
            state_next.phase      = PH_RECOG;
            state_next.hold_timer = '0;
            began                 = 1'b1;
          end else begin
            state_next.hold_timer = tsat;
          end
        end
      end
      REQ_RESET: begin
        state_next.phase      = PH_IDLE;
        state_next.hold_timer = '0;
        state_next.start_x    = '0;
        state_next.start_y    = '0;
        state_next.start_id   = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (state_next.phase)
      PH_PRESSING: res.phase_after = PHASE_CODE_PRESSING;
      PH_RECOG:    res.phase_after = PHASE_CODE_RECOG;
      default:     res.phase_after = PHASE_CODE_IDLE;
    endcase
    res.press_valid       = (state_next.phase == PH_RECOG);
    res.long_press_began  = began;
    res.long_press_failed = failed;
  end

endmodule

[rtl/long_press_detector_top.sv]
// long_press_detector_top: long press recognizer over a stream of touch events
//
//   channel  direction  handshake              payload
//   evt      in         evt_valid / evt_stall  evt_t (one touch event or tick)
//   res      out        res_valid / res_stall  res_t (one result per event)
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result per event; an accepted event sits in the input register and moves to
// the result register when that register is free or its content leaves; its
// result is then held on res until it transfers
// sustained rate is one event per cycle while res is not stalled: the event register,
// the step logic and the result register form a two-stage path with no feedback wait
// rst is synchronous and active high; it clears phase, timer, start position,
// start id and loads the register defaults (min_press_time 500000, travel 10)
// a stall on res holds the result register and, once the input register is
// also full, raises evt_stall in the same cycle
module long_press_detector_top
  import lpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     evt_valid,
  output logic                     evt_stall,
  input  evt_t                     evt,
  output logic                     res_valid,
  input  logic                     res_stall,
  output res_t                     res,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // configuration: travel allowance kept as its square
  logic [TIMER_BITS-1:0] min_press_time;
  logic [ASQ_BITS-1:0]   allow_sq;
  logic [ALLOW_BITS-1:0] allow_wr;

  // event register
  logic  evt_q_vld;
  evt_t  evt_q;

  // recogniser state
  lpd_state_t state;
  lpd_state_t state_next;
  res_t       res_next;

  logic advance;

  assign cfg_ready = 1'b1;
  assign allow_wr  = cfg_data[ALLOW_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_press_time <= MIN_PRESS_TIME_RST;
      allow_sq       <= ALLOW_SQ_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_PRESS_TIME: min_press_time <= cfg_data[TIMER_BITS-1:0];
        CFG_ALLOW_MOVEMENT: allow_sq <= ASQ_BITS'(allow_wr) * ASQ_BITS'(allow_wr);
        default: begin
        end
      endcase
    end
  end

  // the result register is free, or its content leaves on this edge
  assign advance   = !res_valid || !res_stall;
  assign evt_stall = evt_q_vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_q_vld <= 1'b0;
    end else if (!evt_stall) begin
      evt_q_vld <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!evt_stall && evt_valid) begin
      evt_q <= evt;
    end
  end

  lpd_step u_step (
    .state          (state),
    .evt            (evt_q),
    .min_press_time (min_press_time),
    .allow_sq       (allow_sq),
    .state_next     (state_next),
    .res            (res_next)
  );

  // state moves only when the event actually moves on to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_IDLE;
      state.hold_timer <= '0;
      state.start_x    <= '0;
      state.start_y    <= '0;
      state.start_id   <= '0;
    end else if (evt_q_vld && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= evt_q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_q_vld && advance) begin
      res <= res_next;
    end
  end

endmodule

[rtl/lpd_checker.sv]
// lpd_checker: port-level checks of the long press detector, with its bind
module lpd_checker
  import lpd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_valid_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.press_valid == (res.phase_after == PHASE_CODE_RECOG))
    else $error("press_valid disagrees with phase");

  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.long_press_began && res.long_press_failed))
    else $error("began and failed pulse together");

  a_began_recog: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.long_press_began |-> res.phase_after == PHASE_CODE_RECOG)
    else $error("began pulse outside recognised phase");

  a_failed_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.long_press_failed |-> res.phase_after == PHASE_CODE_IDLE)
    else $error("failed pulse outside idle phase");

endmodule

bind long_press_detector_top lpd_checker u_lpd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

[sim/long_press_detector_top_tb.sv]
// long_press_detector_top_tb: self-checking bench for the long press detector top level
module long_press_detector_top_tb;
  import lpd_pkg::*;

  // event kinds and register indexes that the block must ignore
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  // wait after the last result, passing the input and result registers with margin
  localparam int SETTLE_CYCLES = 6;

  // results that can be read straight off the event
  localparam res_t RES_IDLE  = {PHASE_CODE_IDLE, 1'b0, 1'b0, 1'b0};
  localparam res_t RES_FAIL  = {PHASE_CODE_IDLE, 1'b0, 1'b0, 1'b1};
  localparam res_t RES_PRESS = {PHASE_CODE_PRESSING, 1'b0, 1'b0, 1'b0};

  // one line of the directed script: event, repeat count, optional typed result
  typedef struct packed {
    evt_t       ev;
    logic [15:0] reps;
    logic       typed;
    res_t       want;
  } script_row_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     evt_valid = 1'b0;
  evt_t                     evt       = '0;
  logic                     res_stall = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     evt_stall;
  logic                     res_valid;
  res_t                     res;
  logic                     cfg_ready;

  // gesture tracking state and register copies
  logic [1:0]            track_phase;
  logic [TIMER_BITS-1:0] track_timer;
  logic [COORD_BITS-1:0] track_x;
  logic [COORD_BITS-1:0] track_y;
  logic [ID_BITS-1:0]    track_id;
  logic [TIMER_BITS-1:0] min_hold;
  logic [ALLOW_BITS-1:0] travel_limit;

  res_t pending_results[$];
  int   fail_count = 0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;

  long_press_detector_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // hard stop well beyond the slowest correct run
  initial begin
    #500_000;
    $display("** long_press_detector_top: FAILED **");
    $finish;
  end

  function automatic evt_t make_evt(input logic [2:0] kind, input logic one,
                                    input logic [ID_BITS-1:0] id,
                                    input logic [COORD_BITS-1:0] x,
                                    input logic [COORD_BITS-1:0] y,
                                    input logic [DT_BITS-1:0] dt);
    evt_t e;
    e.req_type         = kind;
    e.one_finger_valid = one;
    e.touch_id         = id;
    e.pos_x            = x;
    e.pos_y            = y;
    e.dt_us            = dt;
    return e;
  endfunction

  // random field values at their own widths
  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [ID_BITS-1:0] rand_id();
    return ID_BITS'($urandom());
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_xy();
    return COORD_BITS'($urandom());
  endfunction

  function automatic logic [DT_BITS-1:0] rand_dt();
    return DT_BITS'($urandom());
  endfunction

  // random coordinate within reach of a start point, clamped to the screen
  function automatic logic [COORD_BITS-1:0] nudge(input int c, input int reach);
    int v;
    v = c + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[COORD_BITS-1:0];
  endfunction

  // advance the tracked gesture by one event and work out its result
  task automatic step_gesture(input evt_t e, output res_t r);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [32:0] sum;
    r = '0;
    case (e.req_type)
      REQ_BEGAN: begin
        if (track_phase == PHASE_CODE_IDLE && e.one_finger_valid) begin
          track_id    = e.touch_id;
          track_x     = e.pos_x;
          track_y     = e.pos_y;
          track_timer = '0;
          track_phase = PHASE_CODE_PRESSING;
        end
      end
      REQ_MOVED: begin
        if (track_phase == PHASE_CODE_PRESSING && e.touch_id == track_id) begin
          dx = (e.pos_x >= track_x) ? 64'(e.pos_x - track_x) : 64'(track_x - e.pos_x);
          dy = (e.pos_y >= track_y) ? 64'(e.pos_y - track_y) : 64'(track_y - e.pos_y);
          if (dx * dx + dy * dy > 64'(travel_limit) * 64'(travel_limit))
            track_phase = PHASE_CODE_IDLE;
        end
      end
      REQ_ENDED: begin
        if (track_phase != PHASE_CODE_RECOG) r.long_press_failed = 1'b1;
        track_phase = PHASE_CODE_IDLE;
      end
      REQ_CANCELLED: begin
        track_phase = PHASE_CODE_IDLE;
      end
      REQ_TICK: begin
        if (track_phase == PHASE_CODE_PRESSING) begin
          // timer saturates rather than wrapping
          sum = {1'b0, track_timer} + 33'(e.dt_us);
          track_timer = sum[32] ? '1 : sum[TIMER_BITS-1:0];
          if (track_timer > min_hold) begin
            track_phase = PHASE_CODE_RECOG;
            track_timer = '0;
            r.long_press_began = 1'b1;
          end
        end
      end
      REQ_RESET: begin
        track_phase = PHASE_CODE_IDLE;
        track_timer = '0;
        track_x     = '0;
        track_y     = '0;
        track_id    = '0;
      end
      default: ;
    endcase
    r.phase_after = track_phase;
    r.press_valid = (track_phase == PHASE_CODE_RECOG);
  endtask

  // offer one event, holding it until the transfer, then record its result
  task automatic push_event(input evt_t e, input bit typed = 1'b0, input res_t want = '0);
    res_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt       <= e;
    do @(posedge clk); while (evt_stall !== 1'b0);
    step_gesture(e, predicted);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_MIN_PRESS_TIME: min_hold = val;
      CFG_ALLOW_MOVEMENT: travel_limit = val[ALLOW_BITS-1:0];
      default: ;
    endcase
  endtask

  // both registers, junk above the travel field, then the unused indexes
  task automatic configure(input logic [TIMER_BITS-1:0] hold,
                           input logic [ALLOW_BITS-1:0] travel);
    write_reg(CFG_MIN_PRESS_TIME, hold);
    write_reg(CFG_ALLOW_MOVEMENT, {(CFG_DATA_BITS - ALLOW_BITS)'($urandom()), travel});
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering events and wait for every outstanding result
  task automatic drain();
    evt_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed presses with random content, the rest raw noise
  task automatic run_gestures(input int count);
    int                 done_items;
    int                 steps;
    int                 pick;
    int                 gx;
    int                 gy;
    int                 reach;
    longint             dt_top;
    logic [ID_BITS-1:0] gid;
    evt_t               e;
    done_items = 0;
    while (done_items < count) begin
      if ($urandom_range(99) < 25) begin
        e.req_type         = 3'($urandom_range(7));
        e.one_finger_valid = rand_bit();
        e.touch_id         = rand_id();
        e.pos_x            = rand_xy();
        e.pos_y            = rand_xy();
        e.dt_us            = rand_dt();
        push_event(e);
        done_items++;
      end else begin
        gid = rand_id();
        gx  = $urandom_range(4095);
        gy  = $urandom_range(4095);
        push_event(make_evt(REQ_BEGAN, 1'b1, gid, COORD_BITS'(gx), COORD_BITS'(gy),
                            rand_dt()));
        steps = $urandom_range(1, 12);
        repeat (steps) begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            // travel around the threshold; now and then a different finger
            reach = int'(travel_limit) + 2;
            push_event(make_evt(REQ_MOVED, rand_bit(),
                                (pick < 4) ? gid + 1'b1 : gid,
                                nudge(gx, reach), nudge(gy, reach), rand_dt()));
          end else if (pick < 45) begin
            push_event(make_evt(REQ_BEGAN, 1'b1, rand_id(), rand_xy(), rand_xy(),
                                rand_dt()));
          end else begin
            // ticks sized so that recognition takes a few of them
            dt_top = longint'(min_hold) / 3 + 1;
            if (dt_top > 65535) dt_top = 65535;
            push_event(make_evt(REQ_TICK, rand_bit(), rand_id(), rand_xy(),
                                rand_xy(), ($urandom_range(9) == 0) ? 16'hFFFF :
                                DT_BITS'($urandom_range(0, int'(dt_top)))));
          end
        end
        pick = $urandom_range(9);
        if (pick < 6)
          push_event(make_evt(REQ_ENDED, rand_bit(), rand_id(), rand_xy(),
                              rand_xy(), rand_dt()));
        else if (pick < 8)
          push_event(make_evt(REQ_CANCELLED, rand_bit(), rand_id(), rand_xy(),
                              rand_xy(), rand_dt()));
        else if (pick < 9)
          push_event(make_evt(REQ_RESET, rand_bit(), rand_id(), rand_xy(),
                              rand_xy(), rand_dt()));
        done_items += steps + 2;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result side: random stall and field-by-field comparison on each transfer
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("phase_after", want.phase_after, res.phase_after);
        check_field("press_valid", want.press_valid, res.press_valid);
        check_field("long_press_began", want.long_press_began, res.long_press_began);
        check_field("long_press_failed", want.long_press_failed, res.long_press_failed);
      end
    end
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    script_row_t script [25];

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    track_phase  = PHASE_CODE_IDLE;
    track_timer  = '0;
    track_x      = '0;
    track_y      = '0;
    track_id     = '0;
    min_hold     = MIN_PRESS_TIME_RST;
    travel_limit = ALLOW_MOVEMENT_RST;

    // directed script on the reset register values (hold 500000 us, travel 10)
    script[0]  = {make_evt(REQ_TICK, 1'b0, 4'h0, 12'h000, 12'h000, 16'hFFFF), 16'd1, 1'b1,
                  RES_IDLE};
    script[1]  = {make_evt(REQ_ENDED, 1'b0, 4'h0, 12'h000, 12'h000, 16'h0000), 16'd1, 1'b1,
                  RES_FAIL};
    script[2]  = {make_evt(REQ_MOVED, 1'b1, 4'h0, 12'hFFF, 12'hFFF, 16'h0000), 16'd1, 1'b1,
                  RES_IDLE};
    script[3]  = {make_evt(REQ_BEGAN, 1'b0, 4'hF, 12'hFFF, 12'hFFF, 16'h0000), 16'd1, 1'b1,
                  RES_IDLE};
    script[4]  = {make_evt(REQ_SPARE_LO, 1'b0, 4'h0, 12'h000, 12'h000, 16'h0000), 16'd1,
                  1'b1, RES_IDLE};
    script[5]  = {make_evt(REQ_SPARE_HI, 1'b1, 4'hF, 12'hFFF, 12'hFFF, 16'hFFFF), 16'd1,
                  1'b1, RES_IDLE};
    script[6]  = {make_evt(REQ_BEGAN, 1'b1, 4'hF, 12'hFFF, 12'h000, 16'h0000), 16'd1, 1'b1,
                  RES_PRESS};
    // began while already pressing, then a move by another finger
    script[7]  = {make_evt(REQ_BEGAN, 1'b1, 4'h3, 12'h000, 12'h000, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[8]  = {make_evt(REQ_MOVED, 1'b0, 4'h3, 12'h000, 12'hFFF, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    // travel exactly on the allowance, then one pixel past it
    script[9]  = {make_evt(REQ_MOVED, 1'b0, 4'hF, 12'hFF9, 12'h008, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[10] = {make_evt(REQ_MOVED, 1'b0, 4'hF, 12'hFF9, 12'h009, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[11] = {make_evt(REQ_CANCELLED, 1'b1, 4'hF, 12'hFFF, 12'hFFF, 16'hFFFF), 16'd1,
                  1'b1, RES_IDLE};
    // hold right up to the minimum, then one microsecond over
    script[12] = {make_evt(REQ_BEGAN, 1'b1, 4'h0, 12'h000, 12'hFFF, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[13] = {make_evt(REQ_TICK, 1'b0, 4'h0, 12'h000, 12'h000, 16'hFFFF), 16'd7, 1'b0,
                  RES_IDLE};
    script[14] = {make_evt(REQ_TICK, 1'b0, 4'h0, 12'h000, 12'h000, 16'd41255), 16'd1, 1'b0,
                  RES_IDLE};
    script[15] = {make_evt(REQ_TICK, 1'b0, 4'h0, 12'h000, 12'h000, 16'd1), 16'd1, 1'b0,
                  RES_IDLE};
    // once recognised, ticks and moves change nothing and end gives no pulse
    script[16] = {make_evt(REQ_TICK, 1'b0, 4'h0, 12'h000, 12'h000, 16'hFFFF), 16'd1, 1'b0,
                  RES_IDLE};
    script[17] = {make_evt(REQ_MOVED, 1'b0, 4'h0, 12'hFFF, 12'h000, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[18] = {make_evt(REQ_ENDED, 1'b0, 4'h0, 12'h000, 12'h000, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[19] = {make_evt(REQ_BEGAN, 1'b1, 4'h5, 12'd123, 12'd456, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[20] = {make_evt(REQ_ENDED, 1'b0, 4'h5, 12'd123, 12'd456, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[21] = {make_evt(REQ_BEGAN, 1'b1, 4'h9, 12'd7, 12'd7, 16'h0000), 16'd1, 1'b0,
                  RES_IDLE};
    script[22] = {make_evt(REQ_TICK, 1'b0, 4'h9, 12'd7, 12'd7, 16'd1000), 16'd1, 1'b0,
                  RES_IDLE};
    script[23] = {make_evt(REQ_RESET, 1'b0, 4'h0, 12'h000, 12'h000, 16'h0000), 16'd1, 1'b1,
                  RES_IDLE};
    script[24] = {make_evt(REQ_TICK, 1'b0, 4'h0, 12'h000, 12'h000, 16'hFFFF), 16'd1, 1'b1,
                  RES_IDLE};

    foreach (script[i])
      repeat (script[i].reps) push_event(script[i].ev, script[i].typed, script[i].want);
    drain();

    // hold just under a lowered minimum, then lower it further to one below the held
    // time while pressing so that a zero tick recognises
    configure(32'd200000, 12'hFFF);
    push_event(make_evt(REQ_BEGAN, 1'b1, 4'hA, 12'd2048, 12'd2048, 16'h0000));
    repeat (3) push_event(make_evt(REQ_TICK, 1'b0, 4'hA, 12'h000, 12'h000, 16'hFFFF));
    drain();
    configure(32'd196604, 12'hFFF);
    push_event(make_evt(REQ_TICK, 1'b0, 4'hA, 12'h000, 12'h000, 16'h0000));
    push_event(make_evt(REQ_ENDED, 1'b0, 4'hA, 12'h000, 12'h000, 16'h0000));
    drain();

    // random traffic over several register settings and idling patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          configure('0, '0);
        end
        1: begin
          idle_pct  = 53;
          stall_pct = 0;
          configure('1, '1);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 53;
          configure($urandom_range(1000, 200000), ALLOW_BITS'($urandom_range(1, 40)));
        end
        default: begin
          idle_pct  = 10;
          stall_pct = 10;
          configure($urandom_range(0, 300000), ALLOW_BITS'($urandom_range(0, 4095)));
        end
      endcase
      run_gestures(275);
      drain();
    end

    if (fail_count == 0)
      $display("** long_press_detector_top: PASSED **");
    else
      $display("** long_press_detector_top: FAILED **");
    $finish;
  end

endmodule
